// ===== rtl/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared widths, key codes, register indexes and state types of the console
// line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int BYTE_W            = 8;
	localparam int LEN_W             = 7;
	localparam int CFG_IDX_W         = 2;
	localparam int LINE_CAPACITY_DEF = 64;

	localparam logic [BYTE_W-1:0] KEY_ESC     = 8'h1B;
	localparam logic [BYTE_W-1:0] KEY_BRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] KEY_RIGHT   = 8'h43;
	localparam logic [BYTE_W-1:0] KEY_LEFT    = 8'h44;

	localparam logic [BYTE_W-1:0] ENTER_RESET = 8'd13;
	localparam logic [BYTE_W-1:0] ERASE_RESET = 8'd127;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERASE = 2'd1;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_FIRST,
		ESC_SECOND
	} esc_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_ERA_RD,
		ST_ERA_WR,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

endpackage

// ===== rtl/cle_key_if.sv =====
// ----------------------------------------------------------------------------
// cle_key_if
// Key byte channel: one received byte per beat.
// ----------------------------------------------------------------------------
interface cle_key_if;
	import cle_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);

endinterface

// ===== rtl/cle_line_if.sv =====
// ----------------------------------------------------------------------------
// cle_line_if
// Line output channel: one character of the emitted line per beat.
// ----------------------------------------------------------------------------
interface cle_line_if;
	import cle_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_char;
	logic              char_valid;
	logic              line_last;
	logic [LEN_W-1:0]  line_length;

	modport source (output valid, output out_char, output char_valid, output line_last,
		output line_length, input ready);
	modport sink (input valid, input out_char, input char_valid, input line_last,
		input line_length, output ready);

endinterface

// ===== rtl/cle_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cle_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface cle_cfg_if;
	import cle_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);

endinterface

// ===== rtl/console_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// console_line_editor_core
// Line editor for raw key bytes: insert at cursor, erase, escape cursor moves
// and line emission on enter, with the line held in a RAM.
// Escape bytes, cursor moves, appends at line end and erases at line end are
// done in the idle state. Insert inside the line: a RAM read and write per moved
// element, then the key is put; erase inside the line: one RAM element per read
// and write. Enter: per beat a RAM read, then an output load that waits on ready.
// Reset at once clears count, cursor, escape phase and output valid, and sets
// default codes; the line RAM is not cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module console_line_editor_core #(
	parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cle_key_if.sink    key,
	cle_line_if.source line,
	cle_cfg_if.sink    cfg
);
	import cle_pkg::*;

	localparam int AW = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

	state_t            state_q, state_d;
	esc_phase_t        esc_q;
	logic              bracket_q;
	logic [LEN_W-1:0]  count_q;
	logic [LEN_W-1:0]  cursor_q;
	logic [LEN_W-1:0]  idx_q;
	logic [BYTE_W-1:0] key_q;
	logic [BYTE_W-1:0] enter_q;
	logic [BYTE_W-1:0] erase_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_char_q;
	logic              char_valid_q;
	logic              line_last_q;
	logic [LEN_W-1:0]  line_length_q;

	logic              acc;
	logic [BYTE_W-1:0] b;
	logic              is_enter, is_erase, is_esc, normal;
	logic              at_end, room;
	logic              emit_last, out_load;
	logic [LEN_W-1:0]  idx_m1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	cle_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (LINE_CAPACITY)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign b         = key.key_byte;
	assign acc       = key.valid && key.ready;
	assign normal    = (esc_q == ESC_NONE);
	assign is_enter  = (b == enter_q);
	assign is_erase  = !is_enter && (b == erase_q);
	assign is_esc    = !is_enter && !is_erase && (b == KEY_ESC);
	assign at_end    = (cursor_q == count_q);
	assign room      = (count_q < CAP);
	assign idx_m1    = idx_q - LEN_W'(1);
	assign emit_last = (count_q == '0) || (idx_q == count_q - LEN_W'(1));
	assign out_load  = (state_q == ST_EMIT_WR) && (!out_valid_q || line.ready);

	assign cfg.ready = 1'b1;

	assign line.valid       = out_valid_q;
	assign line.out_char    = out_char_q;
	assign line.char_valid  = char_valid_q;
	assign line.line_last   = line_last_q;
	assign line.line_length = line_length_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && normal) begin
					if (is_enter) begin
						state_d = ST_EMIT_RD;
					end else if (is_erase) begin
						if (cursor_q != '0 && !at_end) state_d = ST_ERA_RD;
					end else if (!is_esc && room && !at_end) begin
						state_d = ST_INS_RD;
					end
				end
			end
			ST_INS_RD:  state_d = ST_INS_WR;
			ST_INS_WR:  state_d = (idx_m1 == cursor_q) ? ST_INS_PUT : ST_INS_RD;
			ST_INS_PUT: state_d = ST_IDLE;
			ST_ERA_RD:  state_d = ST_ERA_WR;
			ST_ERA_WR:  state_d = (idx_q + LEN_W'(1) == count_q) ? ST_IDLE : ST_ERA_RD;
			ST_EMIT_RD: state_d = ST_EMIT_WR;
			ST_EMIT_WR: begin
				if (out_load) state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		key.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				key.ready = 1'b1;
				ram_waddr = cursor_q[AW-1:0];
				ram_wdata = b;
				ram_we    = acc && normal && !is_enter && !is_erase && !is_esc && room
					&& at_end;
			end
			ST_INS_RD: ram_raddr = idx_m1[AW-1:0];
			ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_raddr = idx_m1[AW-1:0];
			end
			ST_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = cursor_q[AW-1:0];
				ram_wdata = key_q;
			end
			ST_ERA_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_m1[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			esc_q       <= ESC_NONE;
			bracket_q   <= 1'b0;
			count_q     <= '0;
			cursor_q    <= '0;
			idx_q       <= '0;
			key_q       <= '0;
			enter_q     <= ENTER_RESET;
			erase_q     <= ERASE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_ENTER) enter_q <= cfg.data;
				if (cfg.index == CFG_ERASE) erase_q <= cfg.data;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (line.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (esc_q)
							ESC_FIRST: begin
								bracket_q <= (b == KEY_BRACKET);
								esc_q     <= ESC_SECOND;
							end
							ESC_SECOND: begin
								if (bracket_q && b == KEY_RIGHT && cursor_q < count_q) begin
									cursor_q <= cursor_q + LEN_W'(1);
								end else if (bracket_q && b == KEY_LEFT && cursor_q != '0) begin
									cursor_q <= cursor_q - LEN_W'(1);
								end
								esc_q     <= ESC_NONE;
								bracket_q <= 1'b0;
							end
							default: begin
								if (is_enter) begin
									idx_q <= '0;
								end else if (is_erase) begin
									if (cursor_q != '0 && at_end) begin
										count_q  <= count_q - LEN_W'(1);
										cursor_q <= cursor_q - LEN_W'(1);
									end else if (cursor_q != '0) begin
										idx_q <= cursor_q;
									end
								end else if (is_esc) begin
									esc_q <= ESC_FIRST;
								end else if (room) begin
									if (at_end) begin
										count_q  <= count_q + LEN_W'(1);
										cursor_q <= cursor_q + LEN_W'(1);
									end else begin
										idx_q <= count_q;
										key_q <= b;
									end
								end
							end
						endcase
					end
				end
				ST_INS_WR: idx_q <= idx_m1;
				ST_INS_PUT: begin
					count_q  <= count_q + LEN_W'(1);
					cursor_q <= cursor_q + LEN_W'(1);
				end
				ST_ERA_WR: begin
					idx_q <= idx_q + LEN_W'(1);
					if (idx_q + LEN_W'(1) == count_q) begin
						count_q  <= count_q - LEN_W'(1);
						cursor_q <= cursor_q - LEN_W'(1);
					end
				end
				ST_EMIT_WR: begin
					if (out_load) begin
						if (emit_last) begin
							count_q  <= '0;
							cursor_q <= '0;
						end else begin
							idx_q <= idx_q + LEN_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q    <= (count_q == '0) ? '0 : ram_rdata;
			char_valid_q  <= (count_q != '0);
			line_last_q   <= emit_last;
			line_length_q <= count_q;
		end
	end

endmodule

// ===== rtl/cle_ram.sv =====
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== dv/cle_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_line_checker
// Watches the key, configuration and line channels of the console line
// editor. Keeps its own line, cursor, escape state and key codes, works out
// the characters each accepted enter key must produce and compares every
// line beat, field by field, against the oldest one still owed.
// ----------------------------------------------------------------------------
module cle_line_checker #(
	parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cle_key_if   key,
	cle_line_if  line,
	cle_cfg_if   cfg,
	output int   mismatches,
	output int   pending
);
	import cle_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] out_char;
		logic              char_valid;
		logic              line_last;
		logic [LEN_W-1:0]  line_length;
	} line_beat_t;

	line_beat_t        owed_chars[$];
	line_beat_t        got;
	line_beat_t        want;
	logic [BYTE_W-1:0] line_buf [LINE_CAPACITY];
	int                line_cnt;
	int                cur_pos;
	esc_phase_t        esc_phase;
	logic              bracket_seen;
	logic [BYTE_W-1:0] enter_key;
	logic [BYTE_W-1:0] erase_key;

	task automatic edit_with_key(input logic [BYTE_W-1:0] b);
		int i;
		case (esc_phase)
		ESC_FIRST: begin
			bracket_seen = (b == KEY_BRACKET);
			esc_phase    = ESC_SECOND;
		end
		ESC_SECOND: begin
			if (bracket_seen) begin
				if (b == KEY_RIGHT && cur_pos < line_cnt)
					cur_pos++;
				else if (b == KEY_LEFT && cur_pos > 0)
					cur_pos--;
			end
			esc_phase    = ESC_NONE;
			bracket_seen = 1'b0;
		end
		default: begin
			if (b == enter_key) begin
				if (line_cnt == 0) begin
					owed_chars.push_back('{out_char: '0, char_valid: 1'b0,
						line_last: 1'b1, line_length: '0});
				end else begin
					for (i = 0; i < line_cnt; i++)
						owed_chars.push_back('{out_char: line_buf[i], char_valid: 1'b1,
							line_last: (i == line_cnt - 1), line_length: LEN_W'(line_cnt)});
				end
				line_cnt = 0;
				cur_pos  = 0;
			end else if (b == erase_key) begin
				if (cur_pos != 0) begin
					for (i = cur_pos; i < line_cnt; i++)
						line_buf[i-1] = line_buf[i];
					line_cnt--;
					cur_pos--;
				end
			end else if (b == KEY_ESC) begin
				esc_phase = ESC_FIRST;
			end else if (line_cnt < LINE_CAPACITY) begin
				for (i = line_cnt; i > cur_pos; i--)
					line_buf[i] = line_buf[i-1];
				line_buf[cur_pos] = b;
				line_cnt++;
				cur_pos++;
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cnt     = 0;
			cur_pos      = 0;
			esc_phase    = ESC_NONE;
			bracket_seen = 1'b0;
			enter_key    = ENTER_RESET;
			erase_key    = ERASE_RESET;
			owed_chars.delete();
		end else begin
			if (line.valid && line.ready) begin
				got = '{out_char: line.out_char, char_valid: line.char_valid,
					line_last: line.line_last, line_length: line.line_length};
				if (owed_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected line beat char %02h valid %0b last %0b len %0d",
							$time, got.out_char, got.char_valid, got.line_last, got.line_length);
				end else begin
					want = owed_chars.pop_front();
					if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
						got.line_last !== want.line_last ||
						got.line_length !== want.line_length) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: line beat mismatch, expected char %02h valid %0b ",
								"last %0b len %0d, got char %02h valid %0b last %0b len %0d"},
								$time, want.out_char, want.char_valid, want.line_last,
								want.line_length, got.out_char, got.char_valid, got.line_last,
								got.line_length);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_ENTER)
					enter_key = cfg.data;
				else if (cfg.index == CFG_ERASE)
					erase_key = cfg.data;
			end
			if (key.valid && key.ready)
				edit_with_key(key.key_byte);
		end
		pending = owed_chars.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives key bytes and code register writes into the console line editor
// core: a short directed opening, code priority checks, then random edited
// lines under four code settings including one overfilled line. The key
// sender runs in bursts, the line receiver stalls on its own pattern, and
// the checker beside the core reports the mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import cle_pkg::*;

	localparam int LINE_CAP      = LINE_CAPACITY_DEF;
	localparam int SETTLE_CYCLES = 2 * LINE_CAP + 16;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_KEYS   = 96;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SLOW
	} rdy_mode_t;

	logic              clk;
	logic              arst_n;
	int                cycle_count = 0;
	int                mismatches;
	int                pending;
	int                burst_left;
	int                keys_sent;
	logic [BYTE_W-1:0] enter_now;
	logic [BYTE_W-1:0] erase_now;

	cle_key_if  key_ch();
	cle_line_if line_ch();
	cle_cfg_if  cfg_ch();

	console_line_editor_core #(
		.LINE_CAPACITY(LINE_CAP)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.key   (key_ch),
		.line  (line_ch),
		.cfg   (cfg_ch)
	);

	cle_line_checker #(
		.LINE_CAPACITY(LINE_CAP)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_ch),
		.line      (line_ch),
		.cfg       (cfg_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("console_line_editor_core verification failed");
		$finish;
	end

	// line receiver: stretches of always ready, coin toss, or one beat in four
	initial begin
		rdy_mode_t mode;
		int        span;
		int        tick;
		tick = 0;
		line_ch.ready <= 1'b0;
		forever begin
			mode = rdy_mode_t'($urandom_range(0, 2));
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
				RDY_ALWAYS: line_ch.ready <= 1'b1;
				RDY_COIN:   line_ch.ready <= 1'($urandom_range(0, 1));
				default:    line_ch.ready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	function automatic logic [BYTE_W-1:0] plain_key();
		logic [BYTE_W-1:0] k;
		do
			k = BYTE_W'($urandom_range(0, 255));
		while (k == enter_now || k == erase_now || k == KEY_ESC);
		return k;
	endfunction

	task automatic send_key(input logic [BYTE_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				key_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 48) :
				$urandom_range(1, 10);
		end
		burst_left--;
		key_ch.valid    <= 1'b1;
		key_ch.key_byte <= b;
		do
			@(posedge clk);
		while (!key_ch.ready);
		@(negedge clk);
		keys_sent++;
	endtask

	task automatic send_esc(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
		send_key(KEY_ESC);
		send_key(first);
		send_key(second);
	endtask

	// hold the key channel until every owed beat is out and the core settles
	task automatic drain();
		key_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic set_codes(input logic [BYTE_W-1:0] enter_code,
		input logic [BYTE_W-1:0] erase_code, input bit spare);
		drain();
		write_reg(CFG_ENTER, enter_code);
		if (spare)
			write_reg(CFG_SPARE_LO, BYTE_W'($urandom_range(0, 255)));
		write_reg(CFG_ERASE, erase_code);
		if (spare)
			write_reg(CFG_SPARE_HI, BYTE_W'($urandom_range(0, 255)));
		cfg_ch.valid <= 1'b0;
		enter_now = enter_code;
		erase_now = erase_code;
	endtask

	task automatic type_line(input int actions);
		int i;
		int pick;
		for (i = 0; i < actions; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_key(plain_key());
			else if (pick < 70)
				send_key(erase_now);
			else if (pick < 78)
				send_esc(KEY_BRACKET, KEY_LEFT);
			else if (pick < 84)
				send_esc(KEY_BRACKET, KEY_RIGHT);
			else if (pick < 88)
				send_esc(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
			else if (pick < 92)
				send_esc(KEY_BRACKET, BYTE_W'($urandom_range(0, 255)));
			else
				send_key(BYTE_W'($urandom_range(0, 255)));
		end
		send_key(enter_now);
	endtask

	// overfill, then edit inside the full line and emit it
	task automatic fill_line();
		repeat (LINE_CAP + 3) send_key(plain_key());
		send_esc(KEY_BRACKET, KEY_LEFT);
		send_esc(KEY_BRACKET, KEY_LEFT);
		send_key(plain_key());
		send_key(erase_now);
		send_key(plain_key());
		send_key(enter_now);
		drain();
	endtask

	initial begin
		int phase;
		int target;
		key_ch.valid    <= 1'b0;
		key_ch.key_byte <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= '0;
		cfg_ch.data     <= '0;
		burst_left = 0;
		keys_sent  = 0;
		enter_now  = ENTER_RESET;
		erase_now  = ERASE_RESET;
		arst_n     = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_key(ENTER_RESET);
		send_key(ERASE_RESET);
		send_esc(KEY_BRACKET, KEY_LEFT);
		send_key(8'h00);
		send_key(8'hFF);
		send_key(8'h61);
		send_esc(KEY_BRACKET, KEY_LEFT);
		send_esc(KEY_BRACKET, KEY_LEFT);
		send_key(8'h78);
		send_key(ERASE_RESET);
		send_esc(ENTER_RESET, ERASE_RESET);
		send_esc(KEY_BRACKET, KEY_RIGHT);
		send_key(ENTER_RESET);

		set_codes(KEY_ESC, KEY_ESC, 1'b0);
		send_key(8'h71);
		send_key(KEY_ESC);
		send_key(KEY_ESC);
		set_codes(8'h00, KEY_ESC, 1'b1);
		send_key(8'h61);
		send_key(8'h62);
		send_key(KEY_ESC);
		send_key(8'h00);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
			0:       set_codes(8'h00, 8'hFF, 1'b0);
			1:       set_codes(8'hFF, 8'h00, 1'b1);
			2:       set_codes(ENTER_RESET, 8'h08, 1'b0);
			default: set_codes(8'h0A, ERASE_RESET, 1'b0);
			endcase
			if (phase == 2)
				fill_line();
			target = keys_sent + RANDOM_KEYS / 4;
			while (keys_sent < target)
				type_line(($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) :
					$urandom_range(0, 5));
		end

		drain();
		if (mismatches == 0 && pending == 0)
			$display("console_line_editor_core verification clean");
		else
			$display("console_line_editor_core verification failed");
		$finish;
	end

endmodule
